>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL files that carry checks.
// Depends on nothing; each macro names the clock and reset it is given.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> hw/rtl/deq_pkg.sv
// Shared constants and types of the double-ended queue.
// Depends on nothing; used by the interfaces and every module.
package deq_pkg;

   // Store geometry.
   localparam int DEPTH   = 16;
   localparam int PTR_W   = $clog2(DEPTH);
   localparam int CNT_W   = $clog2(DEPTH + 1);
   localparam int SUM_W   = CNT_W + 1;
   localparam int ENTRY_W = 32;
   localparam int OP_W    = 3;
   localparam int STAT_W  = 2;
   localparam int OCC_W   = 5;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
   localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
   localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
   localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
   localparam logic [OP_W-1:0] OP_PEEK_FRONT = 3'd4;
   localparam logic [OP_W-1:0] OP_PEEK_BACK  = 3'd5;

   // Status codes.
   localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY = 2'd1;
   localparam logic [STAT_W-1:0] ST_FULL  = 2'd2;

   // Source of the result value.
   typedef enum logic [1:0] {
      RSEL_ZERO,
      RSEL_ONES,
      RSEL_MEM
   } rsel_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;  // an input transfer happens this cycle
      logic load;    // move the resolved result into the output register
   } deq_cmd_type;

endpackage

>>> hw/rtl/deq_if.sv
// Valid/ready channel interfaces for requests and responses.
// Depends on deq_pkg for field widths.
interface deq_req_if;
   logic                                 valid;
   logic                                 ready;
   logic [deq_pkg::OP_W-1:0]             opcode;
   logic signed [deq_pkg::ENTRY_W-1:0]   value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface deq_rsp_if;
   logic                                 valid;
   logic                                 ready;
   logic signed [deq_pkg::ENTRY_W-1:0]   result_value;
   logic [deq_pkg::STAT_W-1:0]           status;
   logic [deq_pkg::OCC_W-1:0]            occupancy;

   modport source (output valid, output result_value, output status, output occupancy,
                   input ready);
   modport sink   (input valid, input result_value, input status, input occupancy,
                   output ready);
endinterface

>>> hw/rtl/deq_ctrl.sv
// Controller of the double-ended queue: sequences one item at a time.
// Depends on deq_pkg for the command struct.
module deq_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output deq_pkg::deq_cmd_type cmd
);

   localparam logic ST_IDLE    = 1'b0;
   localparam logic ST_RESOLVE = 1'b1;

   logic state_ff, state_in;
   logic out_valid_ff, out_valid_in;
   logic out_free;

   // The output register can take a new result when empty or being drained.
   assign out_free   = !out_valid_ff || rsp_ready;
   assign req_ready  = (state_ff == ST_IDLE);
   assign cmd.accept = req_valid && req_ready;
   assign cmd.load   = (state_ff == ST_RESOLVE) && out_free;
   assign rsp_valid  = out_valid_ff;

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (cmd.accept) state_in = ST_RESOLVE;
         end
         ST_RESOLVE: begin
            if (out_free) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Output valid follows loads and response transfers.
   always_comb begin
      out_valid_in = out_valid_ff;
      if (cmd.load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

>>> hw/rtl/deq_dpath.sv
// Datapath of the double-ended queue: entry store, indices and result register.
// Depends on deq_pkg for widths, codes and the command struct.
module deq_dpath (
   input  logic                                clock,
   input  logic                                reset,
   input  deq_pkg::deq_cmd_type                cmd,
   input  logic [deq_pkg::OP_W-1:0]            opcode,
   input  logic signed [deq_pkg::ENTRY_W-1:0]  value,
   output logic signed [deq_pkg::ENTRY_W-1:0]  result_value,
   output logic [deq_pkg::STAT_W-1:0]          status,
   output logic [deq_pkg::OCC_W-1:0]           occupancy
);

   localparam int PTR_W = deq_pkg::PTR_W;
   localparam int CNT_W = deq_pkg::CNT_W;
   localparam int SUM_W = deq_pkg::SUM_W;

   logic [deq_pkg::ENTRY_W-1:0] mem [deq_pkg::DEPTH];

   logic [PTR_W-1:0]             head_ff, head_in;
   logic [CNT_W-1:0]             count_ff, count_in;
   logic [deq_pkg::ENTRY_W-1:0]  rd_data_ff;
   deq_pkg::rsel_type            rsel_ff, rsel_in;
   logic [deq_pkg::STAT_W-1:0]   stat_ff, stat_in;
   logic signed [deq_pkg::ENTRY_W-1:0] out_value_ff, out_value_in;
   logic [deq_pkg::STAT_W-1:0]   out_stat_ff;
   logic [deq_pkg::OCC_W-1:0]    out_occ_ff;

   logic                         full, empty, we;
   logic [PTR_W-1:0]             head_inc, head_dec, tail_pos, back_pos, waddr, raddr;
   logic [SUM_W-1:0]             sum, back_sum;

   // Position arithmetic; each sum stays below twice the depth while not empty.
   assign full     = (count_ff == CNT_W'(deq_pkg::DEPTH));
   assign empty    = (count_ff == '0);
   assign head_inc = (head_ff == PTR_W'(deq_pkg::DEPTH - 1)) ? '0 : head_ff + 1'b1;
   assign head_dec = (head_ff == '0) ? PTR_W'(deq_pkg::DEPTH - 1) : head_ff - 1'b1;
   assign sum      = SUM_W'(head_ff) + SUM_W'(count_ff);
   assign back_sum = sum - 1'b1;
   assign tail_pos = (sum >= SUM_W'(deq_pkg::DEPTH)) ?
                     PTR_W'(sum - SUM_W'(deq_pkg::DEPTH)) : PTR_W'(sum);
   assign back_pos = (back_sum >= SUM_W'(deq_pkg::DEPTH)) ?
                     PTR_W'(back_sum - SUM_W'(deq_pkg::DEPTH)) : PTR_W'(back_sum);

   // Decode the operation into store access and index updates.
   always_comb begin
      head_in  = head_ff;
      count_in = count_ff;
      we       = 1'b0;
      waddr    = tail_pos;
      raddr    = head_ff;
      rsel_in  = deq_pkg::RSEL_ZERO;
      stat_in  = deq_pkg::ST_OK;
      unique case (opcode) inside
         deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
            if (full) begin
               stat_in = deq_pkg::ST_FULL;
            end else begin
               we       = 1'b1;
               count_in = count_ff + 1'b1;
               if (opcode == deq_pkg::OP_PUSH_FRONT) begin
                  waddr   = head_dec;
                  head_in = head_dec;
               end
            end
         end
         deq_pkg::OP_POP_BACK, deq_pkg::OP_POP_FRONT,
         deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK: begin
            if (empty) begin
               rsel_in = deq_pkg::RSEL_ONES;
               stat_in = deq_pkg::ST_EMPTY;
            end else begin
               rsel_in = deq_pkg::RSEL_MEM;
               if (opcode == deq_pkg::OP_POP_BACK || opcode == deq_pkg::OP_PEEK_BACK) begin
                  raddr = back_pos;
               end
               if (opcode == deq_pkg::OP_POP_BACK) begin
                  count_in = count_ff - 1'b1;
               end
               if (opcode == deq_pkg::OP_POP_FRONT) begin
                  head_in  = head_inc;
                  count_in = count_ff - 1'b1;
               end
            end
         end
         default: begin
         end
      endcase
   end

   // Entry store write port.
   always_ff @(posedge clock) begin
      if (cmd.accept && we) mem[waddr] <= value;
   end

   // Entry store read port, registered.
   always_ff @(posedge clock) begin
      if (cmd.accept) rd_data_ff <= mem[raddr];
   end

   // Queue indices.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         count_ff <= '0;
      end else if (cmd.accept) begin
         head_ff  <= head_in;
         count_ff <= count_in;
      end
   end

   // Per-item decode results held for the resolve cycle.
   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         rsel_ff <= rsel_in;
         stat_ff <= stat_in;
      end
   end

   // Choose the result value.
   always_comb begin
      case (rsel_ff)
         deq_pkg::RSEL_ONES: out_value_in = '1;
         deq_pkg::RSEL_MEM:  out_value_in = rd_data_ff;
         default:            out_value_in = '0;
      endcase
   end

   // Output register, loaded when the controller resolves an item.
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         out_value_ff <= out_value_in;
         out_stat_ff  <= stat_ff;
         out_occ_ff   <= deq_pkg::OCC_W'(count_ff);
      end
   end

   assign result_value = out_value_ff;
   assign status       = out_stat_ff;
   assign occupancy    = out_occ_ff;

endmodule

>>> hw/rtl/double_ended_queue_unit.sv
// Top level of the double-ended queue: controller, datapath and checks.
// Depends on deq_pkg, deq_if, deq_ctrl, deq_dpath and assert_macros.svh.
//
//   Channel   Dir  Handshake         Payload
//   req_chan  in   valid / ready     opcode, value
//   rsp_chan  out  valid / ready     result_value, status, occupancy
//
// In the transfer cycle an item updates the indices, writes the store and
// reads it into a register; the resolve state then loads the result.
// The store's single registered read port is why the result resolves separately.
// Reset clears the head index, count and control; store contents stay undefined.
// A new request is taken while a finished response waits in the output register;
// a stalled response holds the controller in its resolve state.
`include "assert_macros.svh"

module double_ended_queue_unit (
   input  logic   clock,
   input  logic   reset,
   deq_req_if.sink   req_chan,
   deq_rsp_if.source rsp_chan
);

   deq_pkg::deq_cmd_type cmd;

   // Sequencing of request and response transfers.
   deq_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_chan.ready),
      .rsp_valid (rsp_chan.valid),
      .rsp_ready (rsp_chan.ready),
      .cmd       (cmd)
   );

   // Store, indices and result register.
   deq_dpath u_dpath (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .opcode       (req_chan.opcode),
      .value        (req_chan.value),
      .result_value (rsp_chan.result_value),
      .status       (rsp_chan.status),
      .occupancy    (rsp_chan.occupancy)
   );

   // One item resolving at a time: after a request transfer the input is closed.
   `ASSERT_NEXT(a_one_in_flight, clock, reset, req_chan.valid && req_chan.ready, !req_chan.ready, "request taken while an item resolves")

   // An empty status always comes with the all-ones value and zero occupancy.
   `ASSERT_SAME(a_empty_value, clock, reset, rsp_chan.valid && rsp_chan.status == deq_pkg::ST_EMPTY, rsp_chan.result_value == -32'sd1 && rsp_chan.occupancy == '0, "empty response malformed")

   // A dropped push is only reported with a full store and a zero value.
   `ASSERT_SAME(a_full_occ, clock, reset, rsp_chan.valid && rsp_chan.status == deq_pkg::ST_FULL, rsp_chan.occupancy == deq_pkg::OCC_W'(deq_pkg::DEPTH) && rsp_chan.result_value == '0, "full response malformed")

   // Occupancy never exceeds the store depth.
   `ASSERT_SAME(a_occ_bound, clock, reset, rsp_chan.valid, rsp_chan.occupancy <= deq_pkg::OCC_W'(deq_pkg::DEPTH), "occupancy above depth")

endmodule

>>> dv/double_ended_queue_unit_tb.sv
// Self-checking testbench for double_ended_queue_unit: random and directed deque traffic.
// Depends on deq_pkg, the deq_req_if and deq_rsp_if interfaces, and the unit itself.
`timescale 1ns / 1ps

module double_ended_queue_unit_tb;

   localparam int ENTRY_W = deq_pkg::ENTRY_W;
   localparam int OP_W    = deq_pkg::OP_W;
   localparam int STAT_W  = deq_pkg::STAT_W;
   localparam int OCC_W   = deq_pkg::OCC_W;
   localparam int DEPTH   = deq_pkg::DEPTH;
   localparam int PTR_W   = deq_pkg::PTR_W;
   localparam int CNT_W   = deq_pkg::CNT_W;

   localparam int RESET_CYCLES = 8;
   localparam int RANDOM_ITEMS = 1830;
   localparam int IDLE_PCT     = 17;
   localparam int HOLD_CYCLES  = 150;
   localparam int DRAIN_LIMIT  = 4000;
   localparam int SETTLE       = 8;
   localparam int CYCLE_LIMIT  = 200000;

   localparam logic [ENTRY_W-1:0] VAL_MAX  = 32'h7fff_ffff;
   localparam logic [ENTRY_W-1:0] VAL_MIN  = 32'h8000_0000;
   localparam logic [ENTRY_W-1:0] VAL_ONES = 32'hffff_ffff;
   localparam logic [OP_W-1:0]    OP_NOP6  = 3'd6;
   localparam logic [OP_W-1:0]    OP_NOP7  = 3'd7;

   typedef enum int {
      MIX_FILL,
      MIX_DRAIN,
      MIX_EVEN
   } traffic_mix_type;

   // One expected response.
   typedef struct packed {
      logic [ENTRY_W-1:0] value;
      logic [STAT_W-1:0]  status;
      logic [OCC_W-1:0]   occupancy;
   } deq_outcome_type;

   // Tracks the deque contents and queues the response each request must produce.
   class deque_scoreboard;
      logic [ENTRY_W-1:0] slots [DEPTH];
      logic [PTR_W-1:0]   head;
      logic [CNT_W-1:0]   count;
      deq_outcome_type    awaited [$];
      int                 mismatches;

      function new();
         head       = '0;
         count      = '0;
         mismatches = 0;
      endfunction

      task report_mismatch(input string what, input logic [31:0] got,
                           input logic [31:0] want);
         mismatches++;
         $display("[%0t] mismatch on %s: got %h, want %h", $realtime, what, got, want);
      endtask

      // Apply one accepted request and queue the response it produces.
      function void note_request(input logic [OP_W-1:0] op,
                                 input logic [ENTRY_W-1:0] val);
         deq_outcome_type  o;
         logic [PTR_W-1:0] tail;
         o.value  = '0;
         o.status = deq_pkg::ST_OK;
         tail     = head + count[PTR_W-1:0] - 1'b1;
         case (op) inside
            deq_pkg::OP_PUSH_BACK, deq_pkg::OP_PUSH_FRONT: begin
               if (count >= DEPTH) begin
                  o.status = deq_pkg::ST_FULL;
               end else if (op == deq_pkg::OP_PUSH_BACK) begin
                  slots[head + count[PTR_W-1:0]] = val;
                  count++;
               end else begin
                  head = head - 1'b1;
                  slots[head] = val;
                  count++;
               end
            end
            deq_pkg::OP_POP_BACK, deq_pkg::OP_POP_FRONT,
            deq_pkg::OP_PEEK_FRONT, deq_pkg::OP_PEEK_BACK: begin
               if (count == 0) begin
                  o.value  = VAL_ONES;
                  o.status = deq_pkg::ST_EMPTY;
               end else if (op == deq_pkg::OP_POP_BACK) begin
                  o.value = slots[tail];
                  count--;
               end else if (op == deq_pkg::OP_POP_FRONT) begin
                  o.value = slots[head];
                  head    = head + 1'b1;
                  count--;
               end else if (op == deq_pkg::OP_PEEK_FRONT) begin
                  o.value = slots[head];
               end else begin
                  o.value = slots[tail];
               end
            end
            default: begin
               // Unused opcodes leave the deque alone.
            end
         endcase
         o.occupancy = count[OCC_W-1:0];
         awaited.push_back(o);
      endfunction

      // Compare one response transfer against the oldest expectation.
      task check_response(input logic [ENTRY_W-1:0] val, input logic [STAT_W-1:0] st,
                          input logic [OCC_W-1:0] occ);
         deq_outcome_type o;
         if (awaited.size() == 0) begin
            report_mismatch("unexpected response", val, '0);
         end else begin
            o = awaited.pop_front();
            if (val !== o.value) report_mismatch("result_value", val, o.value);
            if (st !== o.status) report_mismatch("status", 32'(st), 32'(o.status));
            if (occ !== o.occupancy) begin
               report_mismatch("occupancy", 32'(occ), 32'(o.occupancy));
            end
         end
      endtask

      function int pending();
         return awaited.size();
      endfunction
   endclass

   logic clock = 1'b0;
   logic reset;
   bit   calm;
   bit   hold_request;
   int   cycles;
   deque_scoreboard sb;

   deq_req_if req_bus ();
   deq_rsp_if rsp_bus ();

   double_ended_queue_unit u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_bus),
      .rsp_chan (rsp_bus)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Offer one request, with an optional random gap first, and wait for its transfer.
   task automatic send_item(input logic [OP_W-1:0] op, input logic [ENTRY_W-1:0] val);
      while (!calm && ($urandom_range(99) < IDLE_PCT)) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.value  <= val;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   // Pick an opcode; the mix steers the deque toward full or empty.
   function automatic logic [OP_W-1:0] pick_op(input traffic_mix_type mix);
      int r;
      int push_pct;
      r = $urandom_range(99);
      push_pct = (mix == MIX_FILL) ? 65 : (mix == MIX_DRAIN) ? 30 : 50;
      if (r < 2) return ($urandom_range(1) != 0) ? OP_NOP7 : OP_NOP6;
      if (r < 2 + push_pct) begin
         return ($urandom_range(1) != 0) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_BACK;
      end
      return OP_W'(deq_pkg::OP_POP_BACK + $urandom_range(3));
   endfunction

   // Mostly random words, with the extremes mixed in now and then.
   function automatic logic [ENTRY_W-1:0] pick_value();
      if ($urandom_range(7) == 0) begin
         case ($urandom_range(3))
            0:       return VAL_MAX;
            1:       return VAL_MIN;
            2:       return '0;
            default: return VAL_ONES;
         endcase
      end
      return $urandom;
   endfunction

   // Watch both channels; a request is noted before a same-edge response is checked.
   always @(posedge clock) begin
      if (!reset && sb != null) begin
         if (req_bus.valid && req_bus.ready) sb.note_request(req_bus.opcode, req_bus.value);
         if (rsp_bus.valid && rsp_bus.ready) begin
            sb.check_response(rsp_bus.result_value, rsp_bus.status, rsp_bus.occupancy);
         end
      end
   end

   // Response side: random back-pressure, plus one long hold-off on request.
   initial begin
      int hold_left;
      hold_left = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_left > 0) begin
            rsp_bus.ready <= 1'b0;
            hold_left--;
         end else if (hold_request) begin
            hold_request = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
         end
      end
   end

   // Watchdog on the whole run.
   initial begin
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("== FAIL ==");
      $finish;
   end

   // Reset, directed items, random items, then drain and judge.
   initial begin
      traffic_mix_type mix;
      int waited;
      sb = new();
      calm = 1'b0;
      hold_request = 1'b0;
      reset <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.opcode <= deq_pkg::OP_PUSH_BACK;
      req_bus.value  <= '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // Every pop and peek on an empty deque.
      send_item(deq_pkg::OP_POP_BACK, '0);
      send_item(deq_pkg::OP_POP_FRONT, '0);
      send_item(deq_pkg::OP_PEEK_FRONT, '0);
      send_item(deq_pkg::OP_PEEK_BACK, '0);

      // Fill from both ends with extreme and patterned values, then push while full.
      send_item(deq_pkg::OP_PUSH_BACK, VAL_MAX);
      send_item(deq_pkg::OP_PUSH_FRONT, VAL_MIN);
      send_item(deq_pkg::OP_PUSH_BACK, '0);
      send_item(deq_pkg::OP_PUSH_FRONT, VAL_ONES);
      for (int i = 4; i < DEPTH; i++) begin
         send_item((i % 2 == 0) ? deq_pkg::OP_PUSH_BACK : deq_pkg::OP_PUSH_FRONT,
                   (i % 2 == 0) ? 32'h5555_5555 + i : 32'haaaa_aaaa - i);
      end
      send_item(deq_pkg::OP_PUSH_FRONT, 32'h1234_5678);

      // Reads and removals at both ends, then an unused opcode.
      send_item(deq_pkg::OP_PEEK_FRONT, '0);
      send_item(deq_pkg::OP_PEEK_BACK, '0);
      send_item(deq_pkg::OP_POP_BACK, '0);
      send_item(deq_pkg::OP_POP_FRONT, '0);
      send_item(OP_NOP6, VAL_ONES);

      // Random traffic in fill, drain and even phases.
      mix = MIX_EVEN;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 30 == 0) mix = traffic_mix_type'($urandom_range(2));
         calm = (n >= 600) && (n < 900);
         if (n == 1200) hold_request = 1'b1;
         send_item(pick_op(mix), pick_value());
      end
      req_bus.valid <= 1'b0;
      calm = 1'b0;

      // Wait for every outstanding response, then let the pipeline settle.
      waited = 0;
      while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      while (sb.pending() != 0) begin
         void'(sb.awaited.pop_front());
         sb.report_mismatch("missing response", '0, '0);
      end

      if (sb.mismatches == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
